>>> design/iie_pkg.sv
`timescale 1ns / 1ps

package iie_pkg;

    localparam int OPCODE_W   = 5;
    localparam int WORD_W     = 64;
    localparam int REG_W      = 5;
    localparam int NUM_REGS   = 32;
    localparam int IMM_W      = 48;
    localparam int RS_LSB     = 53;
    localparam int RT_LSB     = 48;
    localparam int LUI_SHIFT  = 32;
    localparam int BRANCH_STEP = 8;

    localparam int MEM_BYTES  = 4096;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROWS       = MEM_BYTES / LANES;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int SIZE_W     = 4;

    localparam logic [OPCODE_W-1:0] OP_ADDI  = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_ADDIU = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_LW    = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_LH    = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_LHU   = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_LB    = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_LBU   = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_SW    = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_SH    = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_SB    = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_LUI   = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_ORI   = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_ANDI  = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_XORI  = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_SLTI  = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_SLTIU = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_BEQ   = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_BNE   = 5'd17;

    typedef logic [LANES-1:0][ROW_W-1:0] row_vec_t;
    typedef logic [LANES-1:0][7:0]       byte_vec_t;

    typedef struct packed {
        logic              wr;
        logic [WORD_W-1:0] val;
        logic              taken;
        logic [WORD_W-1:0] target;
        logic [WORD_W-1:0] ea;
    } alu_res_t;

    function automatic logic is_load(input logic [OPCODE_W-1:0] op);
        return (op == OP_LW) || (op == OP_LH) || (op == OP_LHU) ||
               (op == OP_LB) || (op == OP_LBU);
    endfunction

    function automatic logic is_store(input logic [OPCODE_W-1:0] op);
        return (op == OP_SW) || (op == OP_SH) || (op == OP_SB);
    endfunction

    function automatic logic [SIZE_W-1:0] access_bytes(input logic [OPCODE_W-1:0] op);
        logic [SIZE_W-1:0] n;
        case (op)
            OP_LW, OP_SW:          n = 4'd8;
            OP_LH, OP_LHU, OP_SH:  n = 4'd4;
            OP_LB, OP_LBU, OP_SB:  n = 4'd1;
            default:               n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] load_extend(input logic [OPCODE_W-1:0] op,
                                                      input logic [WORD_W-1:0]   raw);
        logic [WORD_W-1:0] v;
        case (op)
            OP_LW:   v = raw;
            OP_LH:   v = {{32{raw[31]}}, raw[31:0]};
            OP_LHU:  v = {32'd0, raw[31:0]};
            OP_LB:   v = {{56{raw[7]}}, raw[7:0]};
            OP_LBU:  v = {56'd0, raw[7:0]};
            default: v = raw;
        endcase
        return v;
    endfunction

endpackage

>>> design/iie_channels.sv
`timescale 1ns / 1ps

interface iie_instr_if import iie_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   instruction_word;
    logic [WORD_W-1:0]   current_pc;

    modport source (output valid, output opcode, output instruction_word,
                    output current_pc, input ready);
    modport sink   (input valid, input opcode, input instruction_word,
                    input current_pc, output ready);
endinterface

interface iie_result_if import iie_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reg_write;
    logic [REG_W-1:0]  reg_index;
    logic [WORD_W-1:0] reg_value;
    logic              branch_taken;
    logic [WORD_W-1:0] branch_target;

    modport source (output valid, output reg_write, output reg_index, output reg_value,
                    output branch_taken, output branch_target, input ready);
    modport sink   (input valid, input reg_write, input reg_index, input reg_value,
                    input branch_taken, input branch_target, output ready);
endinterface

>>> design/immediate_instruction_execute_top.sv
`timescale 1ns / 1ps

// Executes one 64-bit I-type instruction per transaction against a 32-entry
// register file and a 4096-byte little-endian data memory held as eight byte
// lanes, so any 1, 4 or 8 byte access, aligned or not, touches each lane at most
// once. Sustained rate is one transaction per cycle while no interlock or output
// stall holds it; operands are read, then address/ALU with lane read, then commit.
// An instruction that reads a register written by the one directly ahead of it,
// or a load directly behind a store, waits for that commit. After reset the data
// memory is cleared one row a cycle over all 512 rows, during which no
// transaction is accepted.
module immediate_instruction_execute_top import iie_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    iie_instr_if.sink    instr,
    iie_result_if.source result
);

    logic             accept;
    logic [REG_W-1:0] in_rs;
    logic [REG_W-1:0] in_rt;

    logic             clearing_reg;
    logic [ROW_W-1:0] clear_row_reg;

    logic                s1_valid_reg;
    logic [OPCODE_W-1:0] s1_op_reg;
    logic [REG_W-1:0]    s1_rs_reg;
    logic [REG_W-1:0]    s1_rt_reg;
    logic [IMM_W-1:0]    s1_imm_reg;
    logic [WORD_W-1:0]   s1_pc_reg;
    logic                s1_a_fwd_reg;
    logic [WORD_W-1:0]   s1_a_val_reg;
    logic                s1_b_fwd_reg;
    logic [WORD_W-1:0]   s1_b_val_reg;

    logic [WORD_W-1:0] rf_a;
    logic [WORD_W-1:0] rf_b;
    logic [WORD_W-1:0] s1_a;
    logic [WORD_W-1:0] s1_b;
    alu_res_t          alu_res;
    logic [LANE_W-1:0] s1_base_lane;
    logic [ROW_W-1:0]  s1_base_row;
    row_vec_t          s1_rows;

    logic                s2_valid_reg;
    logic [OPCODE_W-1:0] s2_op_reg;
    logic [REG_W-1:0]    s2_rt_reg;
    logic                s2_wr_reg;
    logic [WORD_W-1:0]   s2_val_reg;
    logic                s2_taken_reg;
    logic [WORD_W-1:0]   s2_target_reg;
    logic [WORD_W-1:0]   s2_b_reg;
    logic [LANE_W-1:0]   s2_base_lane_reg;
    row_vec_t            s2_rows_reg;

    logic                out_valid_reg;
    logic                out_wr_reg;
    logic [REG_W-1:0]    out_index_reg;
    logic [WORD_W-1:0]   out_value_reg;
    logic                out_taken_reg;
    logic [WORD_W-1:0]   out_target_reg;

    logic              hazard;
    logic              s1_adv;
    logic              s2_commit;
    logic              rf_we;
    logic [WORD_W-1:0] commit_value;
    logic [WORD_W-1:0] load_raw;

    byte_vec_t         mem_q;
    logic [LANES-1:0]  mem_we;
    row_vec_t          mem_wrow;
    byte_vec_t         mem_wdata;

    assign in_rs  = instr.instruction_word[RS_LSB +: REG_W];
    assign in_rt  = instr.instruction_word[RT_LSB +: REG_W];
    assign accept = instr.valid && instr.ready;

    // interlocks: register written by the item ahead, or load behind a store
    assign hazard = s2_valid_reg &&
                    ((s2_wr_reg && (s2_rt_reg == s1_rs_reg || s2_rt_reg == s1_rt_reg)) ||
                     (is_load(s1_op_reg) && is_store(s2_op_reg)));
    assign s2_commit   = s2_valid_reg && (!out_valid_reg || result.ready);
    assign s1_adv      = s1_valid_reg && !hazard && (!s2_valid_reg || s2_commit);
    assign instr.ready = !clearing_reg && (!s1_valid_reg || s1_adv);

    assign rf_we = s2_commit && s2_wr_reg;

    iie_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (in_rs),
        .rd_addr_b (in_rt),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_we),
        .wr_addr   (s2_rt_reg),
        .wr_data   (commit_value)
    );

    // memory clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_row_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_row_reg <= clear_row_reg + 1'b1;
            if (clear_row_reg == ROW_W'(ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage 1: register operands, forwarded from commits while waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_a_fwd_reg <= 1'b0;
            s1_b_fwd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_a_fwd_reg <= rf_we && (s2_rt_reg == in_rs);
                s1_b_fwd_reg <= rf_we && (s2_rt_reg == in_rt);
            end
            else
            begin
                if (s1_adv)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (rf_we && (s2_rt_reg == s1_rs_reg))
                begin
                    s1_a_fwd_reg <= 1'b1;
                end
                if (rf_we && (s2_rt_reg == s1_rt_reg))
                begin
                    s1_b_fwd_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= instr.opcode;
            s1_rs_reg    <= in_rs;
            s1_rt_reg    <= in_rt;
            s1_imm_reg   <= instr.instruction_word[IMM_W-1:0];
            s1_pc_reg    <= instr.current_pc;
            s1_a_val_reg <= commit_value;
            s1_b_val_reg <= commit_value;
        end
        else
        begin
            if (rf_we && (s2_rt_reg == s1_rs_reg))
            begin
                s1_a_val_reg <= commit_value;
            end
            if (rf_we && (s2_rt_reg == s1_rt_reg))
            begin
                s1_b_val_reg <= commit_value;
            end
        end
    end

    assign s1_a = s1_a_fwd_reg ? s1_a_val_reg : rf_a;
    assign s1_b = s1_b_fwd_reg ? s1_b_val_reg : rf_b;

    iie_alu u_alu
    (
        .op  (s1_op_reg),
        .a   (s1_a),
        .b   (s1_b),
        .imm (s1_imm_reg),
        .pc  (s1_pc_reg),
        .res (alu_res)
    );

    assign s1_base_lane = alu_res.ea[LANE_W-1:0];
    assign s1_base_row  = alu_res.ea[ADDR_W-1:LANE_W];

    // lanes below the base lane belong to the next row
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            s1_rows[l] = (LANE_W'(l) < s1_base_lane) ? s1_base_row + 1'b1 : s1_base_row;
        end
    end

    // stage 2: lane data back, commit on hand-off to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_commit)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_op_reg        <= s1_op_reg;
            s2_rt_reg        <= s1_rt_reg;
            s2_wr_reg        <= alu_res.wr;
            s2_val_reg       <= alu_res.val;
            s2_taken_reg     <= alu_res.taken;
            s2_target_reg    <= alu_res.target;
            s2_b_reg         <= s1_b;
            s2_base_lane_reg <= s1_base_lane;
            s2_rows_reg      <= s1_rows;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            load_raw[8*i +: 8] = mem_q[s2_base_lane_reg + LANE_W'(i)];
        end
    end

    assign commit_value = is_load(s2_op_reg) ? load_extend(s2_op_reg, load_raw) : s2_val_reg;

    always_comb
    begin
        logic [LANE_W-1:0] idx;
        for (int l = 0; l < LANES; l++)
        begin
            idx = LANE_W'(l) - s2_base_lane_reg;
            if (clearing_reg)
            begin
                mem_we[l]    = 1'b1;
                mem_wrow[l]  = clear_row_reg;
                mem_wdata[l] = '0;
            end
            else
            begin
                mem_we[l]    = s2_commit && is_store(s2_op_reg) &&
                               ({1'b0, idx} < access_bytes(s2_op_reg));
                mem_wrow[l]  = s2_rows_reg[l];
                mem_wdata[l] = s2_b_reg[8*idx +: 8];
            end
        end
    end

    iie_data_mem u_data_mem
    (
        .clk     (clk),
        .rd_en   (s1_adv && is_load(s1_op_reg)),
        .rd_row  (s1_rows),
        .rd_data (mem_q),
        .wr_en   (mem_we),
        .wr_row  (mem_wrow),
        .wr_data (mem_wdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_commit)
        begin
            out_wr_reg     <= s2_wr_reg;
            out_index_reg  <= s2_wr_reg ? s2_rt_reg : '0;
            out_value_reg  <= s2_wr_reg ? commit_value : '0;
            out_taken_reg  <= s2_taken_reg;
            out_target_reg <= s2_target_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.reg_write     = out_wr_reg;
    assign result.reg_index     = out_index_reg;
    assign result.reg_value     = out_value_reg;
    assign result.branch_taken  = out_taken_reg;
    assign result.branch_target = out_target_reg;

endmodule

>>> design/iie_regfile.sv
`timescale 1ns / 1ps

module iie_regfile import iie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [REG_W-1:0]  rd_addr_a,
    input  logic [REG_W-1:0]  rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [REG_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0]   ram_reg [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [WORD_W-1:0]   q_a_reg;
    logic [WORD_W-1:0]   q_b_reg;
    logic                qv_a_reg;
    logic                qv_b_reg;

    // entries not yet written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            qv_a_reg <= 1'b0;
            qv_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                qv_a_reg <= vld_reg[rd_addr_a];
                qv_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_a_reg <= ram_reg[rd_addr_a];
            q_b_reg <= ram_reg[rd_addr_b];
        end
    end

    assign rd_data_a = qv_a_reg ? q_a_reg : '0;
    assign rd_data_b = qv_b_reg ? q_b_reg : '0;

endmodule

>>> design/iie_data_mem.sv
`timescale 1ns / 1ps

module iie_data_mem import iie_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  row_vec_t         rd_row,
    output byte_vec_t        rd_data,
    input  logic [LANES-1:0] wr_en,
    input  row_vec_t         wr_row,
    input  byte_vec_t        wr_data
);

    // one byte lane per memory, each addressed by its own row
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [7:0] ram_reg [ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[l])
            begin
                ram_reg[wr_row[l]] <= wr_data[l];
            end
            if (rd_en)
            begin
                q_reg <= ram_reg[rd_row[l]];
            end
        end

        assign rd_data[l] = q_reg;
    end

endmodule

>>> design/iie_alu.sv
`timescale 1ns / 1ps

module iie_alu import iie_pkg::*;
(
    input  logic [OPCODE_W-1:0] op,
    input  logic [WORD_W-1:0]   a,
    input  logic [WORD_W-1:0]   b,
    input  logic [IMM_W-1:0]    imm,
    input  logic [WORD_W-1:0]   pc,
    output alu_res_t            res
);

    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] zimm;

    assign simm = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
    assign zimm = {{(WORD_W-IMM_W){1'b0}}, imm};

    always_comb
    begin
        res.wr     = 1'b0;
        res.val    = '0;
        res.taken  = 1'b0;
        res.target = '0;
        res.ea     = a + simm;
        case (op)
            OP_ADDI:
            begin
                res.wr  = 1'b1;
                res.val = a + simm;
            end
            OP_ADDIU:
            begin
                res.wr  = 1'b1;
                res.val = a + zimm;
            end
            OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU:
            begin
                res.wr = 1'b1;
            end
            OP_LUI:
            begin
                res.wr  = 1'b1;
                res.val = {imm[WORD_W-LUI_SHIFT-1:0], {LUI_SHIFT{1'b0}}};
            end
            OP_ORI:
            begin
                res.wr  = 1'b1;
                res.val = a | zimm;
            end
            OP_ANDI:
            begin
                res.wr  = 1'b1;
                res.val = a & zimm;
            end
            OP_XORI:
            begin
                res.wr  = 1'b1;
                res.val = a ^ zimm;
            end
            OP_SLTI:
            begin
                res.wr  = 1'b1;
                res.val = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(simm))};
            end
            OP_SLTIU:
            begin
                res.wr  = 1'b1;
                res.val = {{(WORD_W-1){1'b0}}, (a < simm)};
            end
            OP_BEQ:
            begin
                res.taken = (a == b);
            end
            OP_BNE:
            begin
                res.taken = (a != b);
            end
            default:
            begin
                res.wr = 1'b0;
            end
        endcase
        if (res.taken)
        begin
            res.target = pc + WORD_W'(BRANCH_STEP) + simm;
        end
    end

endmodule

>>> tb/sv/immediate_instruction_execute_top_tb.sv
`timescale 1ns / 1ps

module immediate_instruction_execute_top_tb;
    import iie_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_TOP = '1;
    localparam int BASE_LO      = 28;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int N_RANDOM     = 1425;
    localparam int DRAIN_AT     = 900;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic              wr;
        logic [REG_W-1:0]  idx;
        logic [WORD_W-1:0] val;
        logic              taken;
        logic [WORD_W-1:0] tgt;
    } exec_res_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [WORD_W-1:0]   insn;
        logic [WORD_W-1:0]   pc;
        logic                typed;
        exec_res_t           fixed;
    } insn_row_t;

    logic clk;
    logic rst_n;

    iie_instr_if  instr_ch ();
    iie_result_if res_ch ();

    immediate_instruction_execute_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (res_ch)
    );

    logic [WORD_W-1:0] gpr [NUM_REGS];
    logic [7:0]        dmem [MEM_BYTES];
    exec_res_t         exec_q [$];
    insn_row_t         dir_rows [$];
    int                mismatches;
    int                results_seen;
    int                burst_left;
    exec_res_t         got;
    exec_res_t         want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic [WORD_W-1:0] fetch_bytes(logic [WORD_W-1:0] addr, int nb);
        logic [WORD_W-1:0] v;
        v = '0;
        for (int i = 0; i < nb; i++)
            v[8*i +: 8] = dmem[(addr + i) % MEM_BYTES];
        return v;
    endfunction

    function automatic void store_bytes(logic [WORD_W-1:0] addr, int nb, logic [WORD_W-1:0] v);
        for (int i = 0; i < nb; i++)
            dmem[(addr + i) % MEM_BYTES] = v[8*i +: 8];
    endfunction

    function automatic exec_res_t execute_insn(logic [OPCODE_W-1:0] op,
                                               logic [WORD_W-1:0] insn,
                                               logic [WORD_W-1:0] pc);
        logic [REG_W-1:0]  rs;
        logic [REG_W-1:0]  rt;
        logic [WORD_W-1:0] imm;
        logic [WORD_W-1:0] simm;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] v;
        logic              wr;
        logic              tk;
        exec_res_t         r;
        rs   = insn[RS_LSB +: REG_W];
        rt   = insn[RT_LSB +: REG_W];
        imm  = {{(WORD_W-IMM_W){1'b0}}, insn[IMM_W-1:0]};
        simm = {{(WORD_W-IMM_W){insn[IMM_W-1]}}, insn[IMM_W-1:0]};
        a    = gpr[rs];
        b    = gpr[rt];
        addr = a + simm;
        wr   = 1'b1;
        tk   = 1'b0;
        v    = '0;
        case (op)
            OP_ADDI:  v = a + simm;
            OP_ADDIU: v = a + imm;
            OP_LW:    v = fetch_bytes(addr, 8);
            OP_LH:
            begin
                v = fetch_bytes(addr, 4);
                v = {{32{v[31]}}, v[31:0]};
            end
            OP_LHU:   v = fetch_bytes(addr, 4);
            OP_LB:
            begin
                v = fetch_bytes(addr, 1);
                v = {{56{v[7]}}, v[7:0]};
            end
            OP_LBU:   v = fetch_bytes(addr, 1);
            OP_SW:
            begin
                wr = 1'b0;
                store_bytes(addr, 8, b);
            end
            OP_SH:
            begin
                wr = 1'b0;
                store_bytes(addr, 4, b);
            end
            OP_SB:
            begin
                wr = 1'b0;
                store_bytes(addr, 1, b);
            end
            OP_LUI:   v = imm << LUI_SHIFT;
            OP_ORI:   v = a | imm;
            OP_ANDI:  v = a & imm;
            OP_XORI:  v = a ^ imm;
            OP_SLTI:  v = ($signed(a) < $signed(simm)) ? 64'd1 : 64'd0;
            OP_SLTIU: v = (a < simm) ? 64'd1 : 64'd0;
            OP_BEQ:
            begin
                wr = 1'b0;
                tk = (a == b);
            end
            OP_BNE:
            begin
                wr = 1'b0;
                tk = (a != b);
            end
            default:  wr = 1'b0;
        endcase
        if (wr)
            gpr[rt] = v;
        r.wr    = wr;
        r.idx   = wr ? rt : '0;
        r.val   = wr ? v : '0;
        r.taken = tk;
        r.tgt   = tk ? pc + 64'(BRANCH_STEP) + simm : '0;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pack_insn(logic [REG_W-1:0] rs, logic [REG_W-1:0] rt,
                                                    logic [IMM_W-1:0] imm);
        return {{(WORD_W-RS_LSB-REG_W){1'b0}}, rs, rt, imm};
    endfunction

    function automatic exec_res_t reg_result(logic [REG_W-1:0] idx, logic [WORD_W-1:0] val);
        exec_res_t r;
        r       = '0;
        r.wr    = 1'b1;
        r.idx   = idx;
        r.val   = val;
        return r;
    endfunction

    function automatic void add_row(logic [OPCODE_W-1:0] op, logic [REG_W-1:0] rs,
                                    logic [REG_W-1:0] rt, logic [IMM_W-1:0] imm,
                                    logic [WORD_W-1:0] pc, logic typed, exec_res_t fixed);
        insn_row_t row;
        row.op    = op;
        row.insn  = pack_insn(rs, rt, imm);
        row.pc    = pc;
        row.typed = typed;
        row.fixed = fixed;
        dir_rows.push_back(row);
    endfunction

    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 4) != 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    @(negedge clk);
                    instr_ch.valid = 1'b0;
                end
            end
        end
        burst_left--;
    endtask

    task automatic offer(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] insn,
                         logic [WORD_W-1:0] pc, logic typed, exec_res_t fixed);
        exec_res_t pred;
        @(negedge clk);
        instr_ch.valid            = 1'b1;
        instr_ch.opcode           = op;
        instr_ch.instruction_word = insn;
        instr_ch.current_pc       = pc;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        pred = execute_insn(op, insn, pc);
        exec_q.push_back(typed ? fixed : pred);
    endtask

    task automatic pick_random(output logic [OPCODE_W-1:0] op, output logic [WORD_W-1:0] insn,
                               output logic [WORD_W-1:0] pc);
        logic [REG_W-1:0] rs;
        logic [REG_W-1:0] rt;
        logic [IMM_W-1:0] imm;
        int               s;
        if ($urandom_range(0, 24) == 0)
            op = OPCODE_W'($urandom_range(OP_BNE + 1, OP_TOP));
        else
            op = OPCODE_W'($urandom_range(OP_ADDI, OP_BNE));
        rs = REG_W'($urandom);
        rt = REG_W'($urandom);
        s  = $urandom_range(0, 127) - 64;
        case ($urandom_range(0, 9))
            0:       imm = '1;
            1:       imm = {1'b1, {(IMM_W-1){1'b0}}};
            2:       imm = {1'b0, {(IMM_W-1){1'b1}}};
            3:       imm = '0;
            4, 5:    imm = 48'({$urandom, $urandom});
            default: imm = 48'(s);
        endcase
        // keep the four base registers 28 to 31 mostly stable so loads see earlier stores
        if (!(op inside {OP_SW, OP_SH, OP_SB}) && rt >= BASE_LO && $urandom_range(0, 7) != 0)
            rt = REG_W'($urandom_range(0, BASE_LO - 1));
        if (op inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB}
            && $urandom_range(0, 4) != 0)
        begin
            rs  = REG_W'(BASE_LO + $urandom_range(0, 3));
            imm = 48'(s);
        end
        if (op inside {OP_BEQ, OP_BNE} && $urandom_range(0, 1) == 1)
            rt = rs;
        insn = {6'($urandom), rs, rt, imm};
        case ($urandom_range(0, 7))
            0:       pc = '1;
            1:       pc = 64'($urandom_range(0, 4095));
            2:       pc = '1 - 64'($urandom_range(0, 31));
            default: pc = {$urandom, $urandom};
        endcase
    endtask

    initial
    begin
        logic [OPCODE_W-1:0] op;
        logic [WORD_W-1:0]   insn;
        logic [WORD_W-1:0]   pc;
        instr_ch.valid            = 1'b0;
        instr_ch.opcode           = '0;
        instr_ch.instruction_word = '0;
        instr_ch.current_pc       = '0;
        mismatches   = 0;
        results_seen = 0;
        burst_left   = 0;
        foreach (gpr[i])
            gpr[i] = '0;
        foreach (dmem[i])
            dmem[i] = '0;

        add_row(OP_ADDI,  0, 1, 48'h7FFF_FFFF_FFFF, '0, 1'b1,
                reg_result(1, 64'h0000_7FFF_FFFF_FFFF));
        add_row(OP_ADDI,  0, 2, 48'h8000_0000_0000, '0, 1'b1,
                reg_result(2, 64'hFFFF_8000_0000_0000));
        add_row(OP_ADDIU, 0, 3, 48'hFFFF_FFFF_FFFF, '0, 1'b1,
                reg_result(3, 64'h0000_FFFF_FFFF_FFFF));
        add_row(OP_LUI,   0, 4, 48'hFFFF_FFFF_FFFF, '0, 1'b1,
                reg_result(4, 64'hFFFF_FFFF_0000_0000));
        add_row(OP_LW,    0, 5, 48'h0, '0, 1'b1, reg_result(5, '0));
        // store across the top of memory wraps to address zero
        add_row(OP_SW,    0, 4, 48'(MEM_BYTES - 4), '0, 1'b1, '0);
        add_row(OP_LW,    0, 6, 48'(MEM_BYTES - 4), '0, 1'b0, '0);
        add_row(OP_LH,    0, 7, 48'h0, '0, 1'b0, '0);
        add_row(OP_LHU,   0, 8, 48'h0, '0, 1'b0, '0);
        add_row(OP_SB,    0, 1, 48'hFFFF_FFFF_FFFF, '0, 1'b1, '0);
        add_row(OP_LB,    0, 9, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0);
        add_row(OP_LBU,   0, 10, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0);
        add_row(OP_SH,    1, 3, 48'h6, '0, 1'b1, '0);
        add_row(OP_LW,    1, 11, 48'h3, '0, 1'b0, '0);
        add_row(OP_ORI,   2, 12, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0);
        add_row(OP_ANDI,  4, 13, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0);
        add_row(OP_XORI,  3, 14, 48'h5555_5555_5555, '0, 1'b0, '0);
        add_row(OP_SLTI,  2, 15, 48'h0, '0, 1'b0, '0);
        add_row(OP_SLTI,  1, 18, 48'h8000_0000_0000, '0, 1'b0, '0);
        add_row(OP_SLTIU, 2, 16, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0);
        add_row(OP_BEQ,   0, 0, 48'hFFFF_FFFF_FFF8, '1, 1'b0, '0);
        add_row(OP_BNE,   1, 2, 48'h7FFF_FFFF_FFFF, '1, 1'b0, '0);
        add_row(OP_BNE,   0, 0, 48'h1234, '1, 1'b1, '0);
        // register zero is an ordinary register here
        add_row(OP_ADDI,  2, 0, 48'h1, '0, 1'b0, '0);
        add_row(OP_ADDIU, 0, 17, 48'h0, '0, 1'b0, '0);
        add_row(OPCODE_W'(OP_BNE + 1), 31, 31, '1, '1, 1'b1, '0);
        add_row(OP_TOP,   31, 31, '1, '1, 1'b1, '0);

        wait (rst_n === 1'b1);
        foreach (dir_rows[i])
        begin
            pace();
            offer(dir_rows[i].op, dir_rows[i].insn, dir_rows[i].pc,
                  dir_rows[i].typed, dir_rows[i].fixed);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == DRAIN_AT)
            begin
                @(negedge clk);
                instr_ch.valid = 1'b0;
                while (exec_q.size() != 0)
                    @(negedge clk);
            end
            pace();
            pick_random(op, insn, pc);
            offer(op, insn, pc, 1'b0, '0);
        end

        @(negedge clk);
        instr_ch.valid = 1'b0;
        while (exec_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [31:0] pat;
        int          mode_left;
        bit          held;
        res_ch.ready = 1'b0;
        pat          = '1;
        mode_left    = 0;
        held         = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            // long hold-off so the pipeline backs up into the input
            if (!held && results_seen >= HOLD_AT)
            begin
                held         = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                pat       = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'd1);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            res_ch.ready = pat[0];
            pat          = {pat[0], pat[31:1]};
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{wr: res_ch.reg_write, idx: res_ch.reg_index, val: res_ch.reg_value,
                    taken: res_ch.branch_taken, tgt: res_ch.branch_target};
            results_seen++;
            if (exec_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction: wr=%0b idx=%0d val=%h taken=%0b tgt=%h",
                             got.wr, got.idx, got.val, got.taken, got.tgt);
            end
            else
            begin
                want = exec_q.pop_front();
                if (got.wr !== want.wr || got.idx !== want.idx || got.val !== want.val ||
                    got.taken !== want.taken || got.tgt !== want.tgt)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch on transaction %0d", results_seen);
                        $display("  expected wr=%0b idx=%0d val=%h taken=%0b tgt=%h",
                                 want.wr, want.idx, want.val, want.taken, want.tgt);
                        $display("  actual   wr=%0b idx=%0d val=%h taken=%0b tgt=%h",
                                 got.wr, got.idx, got.val, got.taken, got.tgt);
                    end
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((instr_ch.valid && instr_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
